// ===== rtl/sacd_pkg.sv =====
// Shared types and constants of the skew-associative cache directory.
package sacd_pkg;

  localparam int MaxSectors = 16;
  localparam int MaxEntries = 256;
  localparam int Ways       = 4;
  localparam int SecW       = 4;
  localparam int SlotW      = 8;
  localparam int AddrW      = SecW + SlotW;
  localparam int Depth      = MaxSectors * MaxEntries;
  localparam int KeyW       = 64;
  localparam int TimeW      = 48;
  localparam int SizeW      = 20;
  localparam int DivW       = 9;
  localparam int WordW      = 32;
  localparam int CfgW       = 20;

  localparam logic [2:0] OpSector = 3'd4;

  typedef enum logic [1:0] {
    REQ_GET,
    REQ_PUT,
    REQ_DEL,
    REQ_RSVD
  } req_e;

  typedef enum logic [2:0] {
    ST_HIT,
    ST_MISS,
    ST_UPDATED,
    ST_INSERTED,
    ST_REPLACED,
    ST_TOO_LARGE,
    ST_DELETED,
    ST_DEL_MISS
  } status_e;

  typedef enum logic [1:0] {
    CFG_SECTORS,
    CFG_ENTRIES,
    CFG_MAX_SIZE,
    CFG_NONE
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_EVAL,
    S_ACT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0]  tag_lo;
    logic [KeyW-1:0]  tag_hi;
    logic [TimeW-1:0] stamp;
    logic [SizeW-1:0] size;
  } entry_t;

  typedef struct packed {
    logic             clear;
    logic [AddrW-1:0] clr_addr;
    logic             load;
    logic             mod_step;
    logic             mod_first;
    logic             mod_last;
    logic [2:0]       op;
    logic [4:0]       bit_idx;
    logic             ev;
    logic [1:0]       way;
    logic             act;
  } dp_cmd_t;

endpackage

// ===== rtl/sacd_ram.sv =====
// Generic single-port-write, registered-read RAM.
module sacd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/sacd_ctrl.sv =====
// Controller state machine that sequences clearing, modulo steps, reads and updates.
module sacd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sacd_pkg::dp_cmd_t cmd_o
);
  import sacd_pkg::*;

  state_e           state_q, state_d;
  logic [AddrW-1:0] clr_q;
  logic [2:0]       op_q;
  logic [4:0]       bit_q;
  logic [1:0]       way_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_MOD;
      S_MOD:   if (bit_q == 5'd0 && op_q == OpSector) state_d = S_READ;
      S_READ:  state_d = S_EVAL;
      S_EVAL:  state_d = (way_q == 2'd3) ? S_ACT : S_READ;
      S_ACT:   state_d = S_OUT;
      S_OUT:   if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      op_q    <= '0;
      bit_q   <= '1;
      way_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_CLEAR: clr_q <= clr_q + 1'b1;
        S_IDLE: begin
          op_q  <= '0;
          bit_q <= '1;
          way_q <= '0;
        end
        S_MOD: begin
          bit_q <= bit_q - 1'b1;
          if (bit_q == 5'd0) op_q <= op_q + 1'b1;
        end
        S_EVAL:  way_q <= way_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_stall_o      = (state_q != S_IDLE);
    out_valid_o     = (state_q == S_OUT);
    cmd_o           = '0;
    cmd_o.clear     = (state_q == S_CLEAR);
    cmd_o.clr_addr  = clr_q;
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.mod_step  = (state_q == S_MOD);
    cmd_o.mod_first = (bit_q == 5'd31);
    cmd_o.mod_last  = (bit_q == 5'd0);
    cmd_o.op        = op_q;
    cmd_o.bit_idx   = bit_q;
    cmd_o.ev        = (state_q == S_EVAL);
    cmd_o.way       = way_q;
    cmd_o.act       = (state_q == S_ACT);
  end

endmodule

// ===== rtl/sacd_dp.sv =====
// Datapath with configuration, modulo unit, directory memory and result registers.
module sacd_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sacd_pkg::dp_cmd_t              cmd_i,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [sacd_pkg::CfgW-1:0]      cfg_data_i,
  input  logic [1:0]                     req_type_i,
  input  logic [sacd_pkg::KeyW-1:0]      key_low_i,
  input  logic [sacd_pkg::KeyW-1:0]      key_high_i,
  input  logic [sacd_pkg::TimeW-1:0]     time_ms_i,
  input  logic [sacd_pkg::SizeW-1:0]     put_size_i,
  output logic [2:0]                     status_o,
  output logic [sacd_pkg::SecW-1:0]      sector_index_o,
  output logic [sacd_pkg::SlotW-1:0]     slot_index_o,
  output logic [sacd_pkg::SizeW-1:0]     stored_size_o
);
  import sacd_pkg::*;

  logic [4:0]       nsec_q;
  logic [DivW-1:0]  nent_q;
  logic [SizeW-1:0] max_q;
  logic [DivW-1:0]  nsec, nent, div;

  req_e             req_q;
  logic [KeyW-1:0]  klo_q, khi_q;
  logic [TimeW-1:0] now_q;
  logic [SizeW-1:0] vsz_q;

  logic [DivW-1:0]  rem_q;
  logic [SecW-1:0]  sec_q;
  logic [SlotW-1:0] slot_q [Ways];
  logic [WordW-1:0] word;
  logic [DivW:0]    r, rn;

  logic             hit_q, best_empty_q;
  logic [1:0]       hit_way_q, best_way_q;
  logic [SizeW-1:0] hit_size_q;
  logic [TimeW-1:0] best_stamp_q;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  entry_t           wdata, rdata;
  logic             match, empty;

  status_e          st;
  logic [SlotW-1:0] slot_sel;
  logic [SizeW-1:0] size_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nsec_q <= 5'd1;
      nent_q <= 9'd256;
      max_q  <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SECTORS:  nsec_q <= cfg_data_i[4:0];
        CFG_ENTRIES:  nent_q <= cfg_data_i[DivW-1:0];
        CFG_MAX_SIZE: max_q  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  always_comb begin
    if (nsec_q == 5'd0) nsec = 9'd1;
    else if (nsec_q > 5'(MaxSectors)) nsec = 9'(MaxSectors);
    else nsec = {4'd0, nsec_q};
    if (nent_q == 9'd0) nent = 9'd1;
    else if (nent_q > 9'(MaxEntries)) nent = 9'(MaxEntries);
    else nent = nent_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_e'(req_type_i);
      klo_q <= (key_low_i == '0 && key_high_i == '0) ? 64'h20 : key_low_i;
      khi_q <= key_high_i;
      now_q <= time_ms_i;
      vsz_q <= put_size_i;
    end
  end

  always_comb begin
    case (cmd_i.op)
      3'd0:    word = klo_q[31:0];
      3'd1:    word = klo_q[63:32];
      3'd2:    word = khi_q[31:0];
      3'd3:    word = klo_q[47:16];
      default: word = {24'd0, khi_q[39:32]};
    endcase
    div = (cmd_i.op == OpSector) ? nsec : nent;
    r   = {(cmd_i.mod_first ? 9'd0 : rem_q), word[cmd_i.bit_idx]};
    rn  = (r >= {1'b0, div}) ? r - {1'b0, div} : r;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_step) begin
      rem_q <= rn[DivW-1:0];
      if (cmd_i.mod_last) begin
        if (cmd_i.op == OpSector) sec_q <= rn[SecW-1:0];
        else slot_q[cmd_i.op[1:0]] <= rn[SlotW-1:0];
      end
    end
  end

  assign raddr = {sec_q, slot_q[cmd_i.way]};
  assign match = (rdata.tag_lo == klo_q) && (rdata.tag_hi == khi_q);
  assign empty = (rdata.size == '0) && (rdata.tag_lo == '0) && (rdata.tag_hi == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev) begin
      if (cmd_i.way == 2'd0) begin
        hit_q        <= match;
        hit_way_q    <= 2'd0;
        hit_size_q   <= rdata.size;
        best_way_q   <= 2'd0;
        best_stamp_q <= rdata.stamp;
        best_empty_q <= empty;
      end else begin
        if (!hit_q && match) begin
          hit_q      <= 1'b1;
          hit_way_q  <= cmd_i.way;
          hit_size_q <= rdata.size;
        end
        if (rdata.stamp < best_stamp_q) begin
          best_way_q   <= cmd_i.way;
          best_stamp_q <= rdata.stamp;
          best_empty_q <= empty;
        end
      end
    end
  end

  always_comb begin
    we       = 1'b0;
    waddr    = {sec_q, slot_q[hit_way_q]};
    wdata    = '0;
    st       = ST_MISS;
    slot_sel = '0;
    size_sel = '0;
    case (req_q)
      REQ_PUT: begin
        if (vsz_q > max_q) begin
          st = ST_TOO_LARGE;
        end else begin
          wdata = '{tag_lo: klo_q, tag_hi: khi_q, stamp: now_q, size: vsz_q};
          we    = 1'b1;
          size_sel = vsz_q;
          if (hit_q) begin
            st       = ST_UPDATED;
            slot_sel = slot_q[hit_way_q];
          end else begin
            st       = best_empty_q ? ST_INSERTED : ST_REPLACED;
            slot_sel = slot_q[best_way_q];
            waddr    = {sec_q, slot_q[best_way_q]};
          end
        end
      end
      REQ_DEL: begin
        if (hit_q) begin
          we       = 1'b1;
          st       = ST_DELETED;
          slot_sel = slot_q[hit_way_q];
        end else begin
          st = ST_DEL_MISS;
        end
      end
      REQ_GET: begin
        if (hit_q) begin
          we       = 1'b1;
          wdata    = '{tag_lo: klo_q, tag_hi: khi_q, stamp: now_q, size: hit_size_q};
          st       = ST_HIT;
          slot_sel = slot_q[hit_way_q];
          size_sel = hit_size_q;
        end
      end
      default: st = ST_MISS;
    endcase
    if (!cmd_i.act) we = 1'b0;
    if (cmd_i.clear) begin
      we    = 1'b1;
      waddr = cmd_i.clr_addr;
      wdata = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.act) begin
      status_o       <= st;
      sector_index_o <= sec_q;
      slot_index_o   <= slot_sel;
      stored_size_o  <= size_sel;
    end
  end

  sacd_ram #(
    .Width($bits(entry_t)),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule

// ===== rtl/skew_assoc_cache_directory.sv =====
// Top level of the 4-way skew-associative cache directory.
// The request channel (in_valid_i, in_stall_o) carries a get, put or delete with a
// 128-bit hash key, the current time and a value size. The response channel
// (out_valid_o, out_stall_i) returns one transaction per request with status, sector,
// slot and stored size. Configuration registers are written through cfg_we_i,
// cfg_idx_i and cfg_data_i while no request is in flight; the user must keep to
// this, as the block does not enforce it. One request is handled at a time.
// Five remainders (the sector and four slots) are computed one dividend bit per
// cycle in a shared restoring modulo unit, followed by four reads of the directory
// memory, each in a read state and an evaluate state, and an update state. The
// response is valid in the output state after the update state, and a new request
// is taken in the cycle after the response is taken. After reset the directory
// memory is cleared one entry per cycle, during which in_stall_o is high. A stalled
// response holds its value and blocks the next request until it is taken.
module skew_assoc_cache_directory (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [sacd_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 req_type_i,
  input  logic [sacd_pkg::KeyW-1:0]  key_low_i,
  input  logic [sacd_pkg::KeyW-1:0]  key_high_i,
  input  logic [sacd_pkg::TimeW-1:0] time_ms_i,
  input  logic [sacd_pkg::SizeW-1:0] put_size_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 status_o,
  output logic [sacd_pkg::SecW-1:0]  sector_index_o,
  output logic [sacd_pkg::SlotW-1:0] slot_index_o,
  output logic [sacd_pkg::SizeW-1:0] stored_size_o
);
  import sacd_pkg::*;

  dp_cmd_t cmd;

  sacd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  sacd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_type_i),
    .key_low_i     (key_low_i),
    .key_high_i    (key_high_i),
    .time_ms_i     (time_ms_i),
    .put_size_i    (put_size_i),
    .status_o      (status_o),
    .sector_index_o(sector_index_o),
    .slot_index_o  (slot_index_o),
    .stored_size_o (stored_size_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> in_stall_o)
    else $error("Request accepted while a response is pending.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_MISS || status_o == ST_TOO_LARGE ||
    status_o == ST_DEL_MISS) |-> slot_index_o == '0 && stored_size_o == '0)
    else $error("Miss response carries a slot or size.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_DELETED |-> stored_size_o == '0)
    else $error("Delete response carries a size.");
`endif

endmodule

// ===== sim/skew_assoc_cache_directory_tb.sv =====
// Self-checking testbench of the skew-associative cache directory with its own directory predictor.
`timescale 1ns / 1ps

module skew_assoc_cache_directory_tb;
  import sacd_pkg::*;

  typedef struct {
    status_e          status;
    logic [SecW-1:0]  sector;
    logic [SlotW-1:0] slot;
    logic [SizeW-1:0] size;
  } dir_resp_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_idx = '0;
  logic [CfgW-1:0]   cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        req_type = '0;
  logic [KeyW-1:0]   key_low = '0;
  logic [KeyW-1:0]   key_high = '0;
  logic [TimeW-1:0]  time_ms = '0;
  logic [SizeW-1:0]  put_size = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        status;
  logic [SecW-1:0]   sector_index;
  logic [SlotW-1:0]  slot_index;
  logic [SizeW-1:0]  stored_size;

  // Predictor state.
  logic [KeyW-1:0]   dir_tag_lo [Depth];
  logic [KeyW-1:0]   dir_tag_hi [Depth];
  logic [TimeW-1:0]  dir_stamp [Depth];
  logic [SizeW-1:0]  dir_size [Depth];
  logic [4:0]        sectors_cfg = 5'd1;
  logic [8:0]        entries_cfg = 9'd256;
  logic [SizeW-1:0]  max_size_cfg = 20'hFFFFF;

  dir_resp_t         pending_resp[$];
  logic [127:0]      key_pool[$];
  logic [TimeW-1:0]  clock_ms = '0;
  int                errors = 0;
  int                mismatches = 0;
  bit                quiet = 1'b0;
  logic              hold_go = 1'b0;
  int                hold_cnt = 0;

  skew_assoc_cache_directory u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .key_low_i      (key_low),
    .key_high_i     (key_high),
    .time_ms_i      (time_ms),
    .put_size_i     (put_size),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .sector_index_o (sector_index),
    .slot_index_o   (slot_index),
    .stored_size_o  (stored_size)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < Depth; i++) begin
      dir_tag_lo[i] = '0;
      dir_tag_hi[i] = '0;
      dir_stamp[i]  = '0;
      dir_size[i]   = '0;
    end
  end

  function automatic void predict_lookup(logic [1:0] req, logic [KeyW-1:0] klo,
                                         logic [KeyW-1:0] khi, logic [TimeW-1:0] now,
                                         logic [SizeW-1:0] vsz);
    int unsigned nsec, nent, sec, best, hit, e;
    int unsigned way_word [Ways];
    int unsigned slot [Ways];
    int unsigned addr [Ways];
    dir_resp_t   r;
    bit          empty;
    if (klo == '0 && khi == '0) klo = 64'h20;
    nsec = sectors_cfg;
    if (nsec == 0) nsec = 1;
    if (nsec > MaxSectors) nsec = MaxSectors;
    nent = entries_cfg;
    if (nent == 0) nent = 1;
    if (nent > MaxEntries) nent = MaxEntries;
    sec = khi[39:32] % nsec;
    way_word[0] = klo[31:0];
    way_word[1] = klo[63:32];
    way_word[2] = khi[31:0];
    way_word[3] = {klo[47:32], klo[31:16]};
    hit = Ways;
    for (int p = 0; p < Ways; p++) begin
      slot[p] = way_word[p] % nent;
      addr[p] = sec * MaxEntries + slot[p];
    end
    for (int p = Ways - 1; p >= 0; p--)
      if (dir_tag_lo[addr[p]] == klo && dir_tag_hi[addr[p]] == khi) hit = p;
    r.sector = SecW'(sec);
    r.slot   = '0;
    r.size   = '0;
    r.status = ST_MISS;
    if (req == REQ_PUT) begin
      if (vsz > max_size_cfg) begin
        r.status = ST_TOO_LARGE;
      end else if (hit < Ways) begin
        dir_size[addr[hit]]  = vsz;
        dir_stamp[addr[hit]] = now;
        r.status = ST_UPDATED;
        r.slot   = SlotW'(slot[hit]);
        r.size   = vsz;
      end else begin
        best = 0;
        for (int p = 1; p < Ways; p++)
          if (dir_stamp[addr[p]] < dir_stamp[addr[best]]) best = p;
        e = addr[best];
        empty = dir_size[e] == '0 && dir_tag_lo[e] == '0 && dir_tag_hi[e] == '0;
        dir_tag_lo[e] = klo;
        dir_tag_hi[e] = khi;
        dir_size[e]   = vsz;
        dir_stamp[e]  = now;
        r.status = empty ? ST_INSERTED : ST_REPLACED;
        r.slot   = SlotW'(slot[best]);
        r.size   = vsz;
      end
    end else if (req == REQ_DEL) begin
      if (hit < Ways) begin
        e = addr[hit];
        dir_tag_lo[e] = '0;
        dir_tag_hi[e] = '0;
        dir_stamp[e]  = '0;
        dir_size[e]   = '0;
        r.status = ST_DELETED;
        r.slot   = SlotW'(slot[hit]);
      end else begin
        r.status = ST_DEL_MISS;
      end
    end else if (req == REQ_GET && hit < Ways) begin
      dir_stamp[addr[hit]] = now;
      r.status = ST_HIT;
      r.slot   = SlotW'(slot[hit]);
      r.size   = dir_size[addr[hit]];
    end
    pending_resp = {pending_resp, r};
  endfunction

  task automatic send_request(logic [1:0] req, logic [KeyW-1:0] klo, logic [KeyW-1:0] khi,
                              logic [TimeW-1:0] now, logic [SizeW-1:0] vsz);
    in_valid   <= 1'b1;
    req_type   <= req;
    key_low    <= klo;
    key_high   <= khi;
    time_ms    <= now;
    put_size   <= vsz;
    do @(posedge clk); while (in_stall);
    predict_lookup(req, klo, khi, now, vsz);
    if (req == REQ_PUT) begin
      key_pool = {key_pool, {khi, klo}};
      if (key_pool.size() > 48) void'(key_pool.pop_front());
    end
    if (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 200 : 8)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] data);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SECTORS:  sectors_cfg  = data[4:0];
      CFG_ENTRIES:  entries_cfg  = data[8:0];
      CFG_MAX_SIZE: max_size_cfg = data;
      default: ;
    endcase
  endtask

  task automatic random_request();
    logic [1:0]       req;
    logic [127:0]     key;
    logic [SizeW-1:0] vsz;
    int               r;
    r = $urandom_range(99);
    req = (r < 40) ? REQ_GET : (r < 75) ? REQ_PUT : (r < 95) ? REQ_DEL : REQ_RSVD;
    r = $urandom_range(99);
    if (key_pool.size() != 0 && r < 65) key = key_pool[$urandom_range(key_pool.size() - 1)];
    else if (r < 70) key = '0;
    else key = {$urandom, $urandom, $urandom, $urandom};
    vsz = ($urandom_range(99) < 80) ? SizeW'($urandom_range(max_size_cfg, 0))
                                    : SizeW'($urandom);
    if ($urandom_range(99) < 85) clock_ms = clock_ms + TimeW'($urandom_range(3));
    else clock_ms = TimeW'({$urandom, $urandom});
    send_request(req, key[63:0], key[127:64], clock_ms, vsz);
  endtask

  task automatic test_directed();
    send_request(REQ_GET, '0, '0, 48'd1, 20'd7);
    send_request(REQ_PUT, '0, '0, 48'd2, 20'd0);
    send_request(REQ_GET, 64'h20, '0, 48'd3, '0);
    send_request(REQ_PUT, '0, '0, 48'd4, 20'd9);
    send_request(REQ_RSVD, '0, '0, 48'd5, '0);
    send_request(REQ_DEL, '0, '0, 48'd6, '0);
    send_request(REQ_DEL, '0, '0, 48'd7, '0);
    send_request(REQ_PUT, '1, '1, '1, '1);
    send_request(REQ_GET, '1, '1, '0, '0);
    send_request(REQ_PUT, 64'h0000_0005_0000_0005, 64'h0000_0005_0000_0005, 48'd8, 20'd1);
    write_reg(CFG_SECTORS, 20'd16);
    write_reg(CFG_ENTRIES, 20'd1);
    write_reg(CFG_MAX_SIZE, 20'd0);
    send_request(REQ_PUT, 64'h1, 64'h0000_00FF_0000_0000, 48'd10, 20'd1);
    for (int i = 1; i <= 5; i++)
      send_request(REQ_PUT, KeyW'(i), 64'h0000_000F_0000_0000, 48'd10, 20'd0);
    send_request(REQ_GET, 64'h3, 64'h0000_000F_0000_0000, 48'd11, '0);
    write_reg(CFG_SECTORS, 20'd0);
    write_reg(CFG_ENTRIES, 20'd0);
    send_request(REQ_PUT, 64'h2, 64'h0, 48'd12, 20'd0);
    write_reg(CFG_SECTORS, 20'd31);
    write_reg(CFG_ENTRIES, 20'd511);
    write_reg(CFG_MAX_SIZE, 20'hFFFFF);
    write_reg(CFG_NONE, 20'hABCDE);
    send_request(REQ_PUT, 64'hFFFF_FFFF_0000_0000, 64'h0000_00FF_FFFF_FFFF, 48'd13, 20'hFFFFF);
    drain();
  endtask

  task automatic test_random_settings();
    logic [CfgW-1:0] ents [8] = '{1, 2, 3, 4, 7, 16, 255, 256};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_SECTORS, CfgW'($urandom_range(31)));
      write_reg(CFG_ENTRIES, ents[$urandom_range(7)]);
      write_reg(CFG_MAX_SIZE, ($urandom_range(3) == 0) ? CfgW'($urandom)
                                                      : CfgW'(20'hFFFFF - $urandom_range(99)));
      quiet = (ph == 3);
      repeat (80) random_request();
      quiet = 1'b0;
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_go <= 1'b1;
    repeat (6) random_request();
    while (hold_cnt < 600) @(posedge clk);
    hold_go <= 1'b0;
    repeat (20) random_request();
    drain();
    repeat (20) random_request();
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_go && hold_cnt < 600) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      if (!hold_go) hold_cnt <= 0;
      out_stall <= !quiet && $urandom_range(99) < 9;
    end
  end

  always @(posedge clk) begin
    dir_resp_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_resp.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("Unexpected transaction: status %0d", status);
      end else begin
        exp_r = pending_resp.pop_front();
        if (status !== exp_r.status || sector_index !== exp_r.sector ||
            slot_index !== exp_r.slot || stored_size !== exp_r.size) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: exp st %0d sec %0d slot %0d size %0d, got %0d %0d %0d %0d",
                     exp_r.status, exp_r.sector, exp_r.slot, exp_r.size,
                     status, sector_index, slot_index, stored_size);
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random_settings();
    test_backpressure();
    repeat (200) @(posedge clk);
    if (pending_resp.size() != 0) errors++;
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
